// File: rtl/box_to_circle_slew_smoother_defines.svh
// ---------------------------------------------------------------------------
// box_to_circle_slew_smoother assertion macros
// shared property shorthands for the circle smoother, clocked on clk, reset rst_n
// ---------------------------------------------------------------------------
`ifndef BOX_TO_CIRCLE_SLEW_SMOOTHER_DEFINES_SVH
`define BOX_TO_CIRCLE_SLEW_SMOOTHER_DEFINES_SVH

// same-cycle implication
`define BCSS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bcss_pkg.sv
// ---------------------------------------------------------------------------
// bcss_pkg
// widths, register codes, reset values and control structs of the smoother
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcss_pkg;

    localparam int OBJ_W      = 3;
    localparam int COORD_W    = 14;
    localparam int RAD_W      = 14;
    localparam int LABEL_W    = 15;
    localparam int SHIFT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int DIFF_W     = 15;
    localparam int SQ_W       = 29;
    localparam int ROOT_W     = 15;
    localparam int REM_W      = 16;
    localparam int ROOT_STEPS = 15;
    localparam int STEP_CNT_W = 4;
    localparam int ENTRY_W    = RAD_W + 2 * COORD_W;

    localparam logic [SHIFT_W-1:0] GROW_SHIFT_RST   = 4'd4;
    localparam logic [SHIFT_W-1:0] SHRINK_SHIFT_RST = 4'd5;
    localparam logic [COORD_W-1:0] VSTEP_RST        = 14'd3;
    localparam logic [COORD_W-1:0] HSTEP_RST        = 14'd20;
    localparam logic [SHIFT_W-1:0] LABEL_SHIFT_RST  = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROW_SHIFT   = 3'd0,
        REG_SHRINK_SHIFT = 3'd1,
        REG_MAX_VSTEP    = 3'd2,
        REG_MAX_HSTEP    = 3'd3,
        REG_LABEL_SHIFT  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic load_in;
        logic square_en;
        logic sum_en;
        logic root_step;
        logic limit_en;
        logic finish;
    } bcss_cmd_t;

    typedef struct packed {
        logic root_last;
    } bcss_sts_t;

endpackage

// File: rtl/bcss_ram.sv
// ---------------------------------------------------------------------------
// bcss_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bcss_ctrl.sv
// ---------------------------------------------------------------------------
// bcss_ctrl
// sequencer of the smoother: accept, square, sum, root loop, limit, finish
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_to_circle_slew_smoother_defines.svh"

module bcss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bcss_pkg::bcss_cmd_t  cmd,
    input  bcss_pkg::bcss_sts_t  sts
);

    import bcss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_LIMIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd           = '0;
        cmd.load_in   = (state_reg == S_IDLE) && in_valid;
        cmd.square_en = (state_reg == S_SQUARE);
        cmd.sum_en    = (state_reg == S_SUM);
        cmd.root_step = (state_reg == S_ROOT);
        cmd.limit_en  = (state_reg == S_LIMIT);
        cmd.finish    = (state_reg == S_FINISH) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE: state_next = S_SUM;
            S_SUM:    state_next = S_ROOT;
            S_ROOT:
            begin
                if (sts.root_last)
                begin
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:  state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `BCSS_ASSERT_SAME(a_finish_slot_free, cmd.finish, !out_valid_reg || !out_stall, "result overwritten")
    `BCSS_ASSERT_NEXT(a_root_to_limit, state_reg == S_ROOT && sts.root_last, state_reg == S_LIMIT, "root loop overrun")
    `BCSS_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_reg == S_SQUARE, "beat accepted without start")

endmodule

// File: rtl/bcss_datapath.sv
// ---------------------------------------------------------------------------
// bcss_datapath
// box to circle arithmetic, root unit, slew limits, object history and config
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcss_datapath #(
    parameter int OBJECTS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bcss_pkg::bcss_cmd_t                 cmd,
    output bcss_pkg::bcss_sts_t                 sts,
    input  logic                                cfg_we,
    input  logic [bcss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [bcss_pkg::OBJ_W-1:0]          object_id,
    input  logic [bcss_pkg::COORD_W-1:0]        left_x,
    input  logic [bcss_pkg::COORD_W-1:0]        top_y,
    input  logic [bcss_pkg::COORD_W-1:0]        right_x,
    input  logic [bcss_pkg::COORD_W-1:0]        bottom_y,
    output logic [bcss_pkg::OBJ_W-1:0]          object_echo,
    output logic [bcss_pkg::COORD_W-1:0]        center_x,
    output logic [bcss_pkg::COORD_W-1:0]        center_y,
    output logic [bcss_pkg::RAD_W-1:0]          radius,
    output logic [bcss_pkg::COORD_W-1:0]        label_x,
    output logic signed [bcss_pkg::LABEL_W-1:0] label_y
);

    import bcss_pkg::*;

    localparam int IDX_W = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;

    function automatic logic [COORD_W-1:0] slew_axis(
        input logic [COORD_W-1:0] raw,
        input logic [COORD_W-1:0] prev,
        input logic [COORD_W-1:0] step
    );
        logic signed [COORD_W+1:0] d;
        logic signed [COORD_W+1:0] s;
        logic [COORD_W-1:0]        res;
        d = signed'({2'b00, raw}) - signed'({2'b00, prev});
        s = signed'({2'b00, step});
        if (d > s)
        begin
            res = COORD_W'(prev + step);
        end
        else if (-d > s)
        begin
            res = COORD_W'(prev - step);
        end
        else
        begin
            res = raw;
        end
        return res;
    endfunction

    // configuration
    logic [SHIFT_W-1:0] grow_shift_reg;
    logic [SHIFT_W-1:0] shrink_shift_reg;
    logic [COORD_W-1:0] vstep_reg;
    logic [COORD_W-1:0] hstep_reg;
    logic [SHIFT_W-1:0] label_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_shift_reg   <= GROW_SHIFT_RST;
            shrink_shift_reg <= SHRINK_SHIFT_RST;
            vstep_reg        <= VSTEP_RST;
            hstep_reg        <= HSTEP_RST;
            label_shift_reg  <= LABEL_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GROW_SHIFT:   grow_shift_reg   <= cfg_data[SHIFT_W-1:0];
                REG_SHRINK_SHIFT: shrink_shift_reg <= cfg_data[SHIFT_W-1:0];
                REG_MAX_VSTEP:    vstep_reg        <= cfg_data[COORD_W-1:0];
                REG_MAX_HSTEP:    hstep_reg        <= cfg_data[COORD_W-1:0];
                REG_LABEL_SHIFT:  label_shift_reg  <= cfg_data[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    // input capture
    logic                     in_range;
    logic [IDX_W-1:0]         in_idx;
    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic [COORD_W:0]         sum_x;
    logic [COORD_W:0]         sum_y;

    assign in_range = ({{(32-OBJ_W){1'b0}}, object_id} < 32'(OBJECTS));
    assign in_idx   = IDX_W'(object_id);
    assign dx_next  = signed'({1'b0, right_x}) - signed'({1'b0, left_x});
    assign dy_next  = signed'({1'b0, bottom_y}) - signed'({1'b0, top_y});
    assign sum_x    = {1'b0, left_x} + {1'b0, right_x};
    assign sum_y    = {1'b0, top_y} + {1'b0, bottom_y};

    logic [OBJ_W-1:0]         obj_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     in_range_reg;
    logic                     smooth_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic [COORD_W-1:0]       cx_raw_reg;
    logic [COORD_W-1:0]       cy_raw_reg;
    logic [OBJECTS-1:0]       seen_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            obj_reg      <= object_id;
            idx_reg      <= in_idx;
            in_range_reg <= in_range;
            smooth_reg   <= in_range ? seen_reg[in_idx] : 1'b0;
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            cx_raw_reg   <= sum_x[COORD_W:1];
            cy_raw_reg   <= sum_y[COORD_W:1];
        end
    end

    // object history
    logic [ENTRY_W-1:0] hist_rdata;
    logic [ENTRY_W-1:0] hist_wdata;
    logic [RAD_W-1:0]   prev_r;
    logic [COORD_W-1:0] prev_cx;
    logic [COORD_W-1:0] prev_cy;
    logic               hist_we;

    assign hist_we = cmd.finish && in_range_reg;
    assign {prev_r, prev_cx, prev_cy} = hist_rdata;

    bcss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (OBJECTS),
        .AW    (IDX_W)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (idx_reg),
        .wdata (hist_wdata),
        .re    (cmd.load_in),
        .raddr (in_idx),
        .rdata (hist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (hist_we)
        begin
            seen_reg[idx_reg] <= 1'b1;
        end
    end

    // squares and diagonal
    logic signed [2*DIFF_W-1:0] sqx_prod;
    logic signed [2*DIFF_W-1:0] sqy_prod;
    logic [SQ_W-1:0]            sqx_reg;
    logic [SQ_W-1:0]            sqy_reg;

    assign sqx_prod = dx_reg * dx_reg;
    assign sqy_prod = dy_reg * dy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.square_en)
        begin
            sqx_reg <= sqx_prod[SQ_W-1:0];
            sqy_reg <= sqy_prod[SQ_W-1:0];
        end
    end

    // square root, one result bit per step
    logic [2*ROOT_W-1:0]    opnd_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [ROOT_W-1:0]      root_reg;
    logic [STEP_CNT_W-1:0]  step_cnt_reg;
    logic [REM_W+1:0]       rem_shift;
    logic [REM_W+1:0]       trial;
    logic                   trial_ok;
    logic [REM_W+1:0]       rem_sub;

    assign rem_shift = {rem_reg, opnd_reg[2*ROOT_W-1:2*ROOT_W-2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign trial_ok  = (rem_shift >= trial);
    assign rem_sub   = rem_shift - trial;

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            opnd_reg     <= {1'b0, sqx_reg + sqy_reg};
            rem_reg      <= '0;
            root_reg     <= '0;
            step_cnt_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            opnd_reg     <= {opnd_reg[2*ROOT_W-3:0], 2'b00};
            step_cnt_reg <= step_cnt_reg + 1'b1;
            if (trial_ok)
            begin
                rem_reg  <= rem_sub[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign sts.root_last = (step_cnt_reg == STEP_CNT_W'(ROOT_STEPS - 1));

    // slew limits
    logic [RAD_W-1:0]         r_raw;
    logic [RAD_W-1:0]         grow;
    logic [RAD_W-1:0]         shrink;
    logic signed [RAD_W+1:0]  r_diff;
    logic [RAD_W-1:0]         r_lim;
    logic [RAD_W-1:0]         r_reg;
    logic [COORD_W-1:0]       cx_reg;
    logic [COORD_W-1:0]       cy_reg;

    assign r_raw  = root_reg[ROOT_W-1:1];
    assign grow   = prev_r >> grow_shift_reg;
    assign shrink = prev_r >> shrink_shift_reg;
    assign r_diff = signed'({2'b00, r_raw}) - signed'({2'b00, prev_r});

    always_comb
    begin
        if (r_diff > signed'({2'b00, grow}))
        begin
            r_lim = RAD_W'(prev_r + grow);
        end
        else if (r_diff < -signed'({2'b00, shrink}))
        begin
            r_lim = RAD_W'(prev_r - shrink);
        end
        else
        begin
            r_lim = r_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.limit_en)
        begin
            if (smooth_reg)
            begin
                r_reg  <= r_lim;
                cx_reg <= slew_axis(cx_raw_reg, prev_cx, hstep_reg);
                cy_reg <= slew_axis(cy_raw_reg, prev_cy, vstep_reg);
            end
            else
            begin
                r_reg  <= r_raw;
                cx_reg <= cx_raw_reg;
                cy_reg <= cy_raw_reg;
            end
        end
    end

    // label and result
    logic signed [LABEL_W:0] ly_full;

    assign ly_full    = signed'({2'b00, cy_reg}) - signed'({2'b00, r_reg >> label_shift_reg});
    assign hist_wdata = {r_reg, cx_reg, cy_reg};

    logic [OBJ_W-1:0]          obj_out_reg;
    logic [COORD_W-1:0]        cx_out_reg;
    logic [COORD_W-1:0]        cy_out_reg;
    logic [RAD_W-1:0]          r_out_reg;
    logic signed [LABEL_W-1:0] ly_out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            obj_out_reg <= obj_reg;
            cx_out_reg  <= cx_reg;
            cy_out_reg  <= cy_reg;
            r_out_reg   <= r_reg;
            ly_out_reg  <= ly_full[LABEL_W-1:0];
        end
    end

    assign object_echo = obj_out_reg;
    assign center_x    = cx_out_reg;
    assign center_y    = cy_out_reg;
    assign radius      = r_out_reg;
    assign label_x     = cx_out_reg;
    assign label_y     = ly_out_reg;

endmodule

// File: rtl/box_to_circle_slew_smoother.sv
// ---------------------------------------------------------------------------
// box_to_circle_slew_smoother
// Turns one tracked object's bounding box per beat into a circle (floored
// corner midpoint, half the integer square root of the squared diagonal),
// slew-limits radius and center against that object's previous circle, and
// returns the circle with a label point above it. One box is processed at a
// time: an accepted beat passes the square, sum, bit-per-step square root
// loop, limit and finish states in order, and the next box is accepted only
// once the previous one has finished. A finished result waits in the output
// register while a stalled sink holds it. Object ids at or above OBJECTS pass
// through unsmoothed and leave no history. The config port is always ready;
// the user must write it only while no beat is in flight; the block doesn't enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_to_circle_slew_smoother #(
    parameter int OBJECTS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bcss_pkg::OBJ_W-1:0]          object_id,
    input  logic [bcss_pkg::COORD_W-1:0]        left_x,
    input  logic [bcss_pkg::COORD_W-1:0]        top_y,
    input  logic [bcss_pkg::COORD_W-1:0]        right_x,
    input  logic [bcss_pkg::COORD_W-1:0]        bottom_y,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bcss_pkg::OBJ_W-1:0]          object_echo,
    output logic [bcss_pkg::COORD_W-1:0]        center_x,
    output logic [bcss_pkg::COORD_W-1:0]        center_y,
    output logic [bcss_pkg::RAD_W-1:0]          radius,
    output logic [bcss_pkg::COORD_W-1:0]        label_x,
    output logic signed [bcss_pkg::LABEL_W-1:0] label_y,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bcss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import bcss_pkg::*;

    bcss_cmd_t cmd;
    bcss_sts_t sts;

    assign cfg_ready = 1'b1;

    bcss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    bcss_datapath #(
        .OBJECTS (OBJECTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .object_id   (object_id),
        .left_x      (left_x),
        .top_y       (top_y),
        .right_x     (right_x),
        .bottom_y    (bottom_y),
        .object_echo (object_echo),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius      (radius),
        .label_x     (label_x),
        .label_y     (label_y)
    );

endmodule
